// ===== hw/rtl/uartrb_pkg.sv =====
package uartrb_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_RTS_STOP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RTS_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_EN = 2'd2;

	localparam logic [7:0] RTS_STOP_RST  = 8'd192;
	localparam logic [7:0] RTS_START_RST = 8'd16;
	localparam logic [7:0] REBOOT_CHAR   = 8'h1a;

	typedef enum logic [1:0] {
		OP_LINE_RX    = 2'd0,
		OP_HOST_READ  = 2'd1,
		OP_HOST_WRITE = 2'd2,
		OP_TX_READY   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] data_byte;
		logic       cts_asserted;
	} req_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       rts_asserted;
		logic [7:0] rx_fill;
		logic [7:0] tx_fill;
		logic       rx_dropped;
		logic       tx_rejected;
		logic       tx_stalled_by_cts;
		logic       reboot_request;
		logic       rx_ready;
	} rsp_t;

endpackage

// ===== hw/rtl/uartrb_ring.sv =====
module uartrb_ring #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     pop,
	input  logic [7:0]               wdata,
	output logic [$clog2(DEPTH)-1:0] fill_nx,
	output logic                     empty,
	output logic                     full,
	output logic [7:0]               rdata_s1
);
	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] fill_q;

	function automatic logic [PW-1:0] ptr_adv(input logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + PW'(1);
	endfunction

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == LAST_IDX);
	assign fill_nx = fill_q + PW'(push) - PW'(pop);

	// pointers start one past slot zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= PW'(1);
			rd_ptr_q <= PW'(1);
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_adv(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_adv(rd_ptr_q);
			fill_q <= fill_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wdata;
		if (pop)
			rdata_s1 <= mem[rd_ptr_q];
	end

endmodule

// ===== hw/rtl/uartrb_oreg.sv =====
module uartrb_oreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  uartrb_pkg::rsp_t  res_s1,
	input  logic [7:0]        tx_rdata_s1,
	input  logic [7:0]        rx_rdata_s1,
	input  logic              stall,
	output logic              take,
	output logic              valid,
	output uartrb_pkg::rsp_t  word
);
	import uartrb_pkg::*;

	logic valid_q;
	rsp_t word_q;
	rsp_t merged;

	assign take = valid_s1 && (!valid_q || !stall);

	// bytes read back as zero when nothing was taken from the ring
	always_comb begin
		merged           = res_s1;
		merged.tx_byte   = res_s1.tx_valid ? tx_rdata_s1 : 8'd0;
		merged.read_byte = res_s1.read_valid ? rx_rdata_s1 : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			word_q <= merged;
	end

	assign valid = valid_q;
	assign word  = word_q;

endmodule

// ===== hw/rtl/uart_ring_buffers_rts_cts.sv =====
// Serial console buffering with RTS/CTS flow control.
// Request channel (req_valid/req_stall/req_word) carries one event per word:
// a byte from the line, a host read, a host write, or a transmitter tick
// that carries the partner's CTS level. Response channel (rsp_*) returns one
// word per request: sent byte, read byte, RTS level, both ring fills and
// the drop/reject/stall/reboot flags.
// Each ring holds RING_DEPTH-1 bytes in an internal RAM with a registered
// read port; the pointer and fill update for an event is done in the cycle
// it is taken, so one request is accepted every clock while req_stall is
// low. An accepted word passes the RAM read register and then the output
// register before it shows with rsp_valid.
// When rsp_stall is high the output word holds, one more request is taken
// into the read stage, then req_stall rises until the output moves.
// Reset empties both rings, asserts RTS and loads the level registers with
// 192 and 16 and reboot detection on; there is no clearing pass.
// cfg_we writes register cfg_index: 0 stop level, 1 start level, 2 reboot
// enable; other indexes are ignored.
module uart_ring_buffers_rts_cts #(
	parameter int RING_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  uartrb_pkg::req_t                 req_word,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output uartrb_pkg::rsp_t                 rsp_word,
	input  logic                             cfg_we,
	input  logic [uartrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uartrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import uartrb_pkg::*;

	localparam int FW = $clog2(RING_DEPTH);
	localparam int LW = (FW > 8) ? FW : 8;

	logic          accept;
	logic          take;
	logic          valid_s1;
	rsp_t          res_s1;
	rsp_t          res;
	logic          rts_q;
	logic          rts_nx;
	logic [7:0]    stop_q;
	logic [7:0]    start_q;
	logic          reboot_en_q;

	logic          rx_push, rx_pop, rx_empty, rx_full;
	logic          tx_push, tx_pop, tx_empty, tx_full;
	logic [FW-1:0] rx_fill_nx, tx_fill_nx;
	logic [7:0]    rx_rdata_s1, tx_rdata_s1;

	assign req_stall = valid_s1 && !take;
	assign accept    = req_valid && !req_stall;

	assign rx_push = accept && (req_word.opcode == OP_LINE_RX) && !rx_full;
	assign rx_pop  = accept && (req_word.opcode == OP_HOST_READ) && !rx_empty;
	assign tx_push = accept && (req_word.opcode == OP_HOST_WRITE) && !tx_full;
	assign tx_pop  = accept && (req_word.opcode == OP_TX_READY) && !tx_empty
		&& req_word.cts_asserted;

	uartrb_ring #(.DEPTH(RING_DEPTH)) u_rx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rx_push),
		.pop      (rx_pop),
		.wdata    (req_word.data_byte),
		.fill_nx  (rx_fill_nx),
		.empty    (rx_empty),
		.full     (rx_full),
		.rdata_s1 (rx_rdata_s1)
	);

	uartrb_ring #(.DEPTH(RING_DEPTH)) u_tx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tx_push),
		.pop      (tx_pop),
		.wdata    (req_word.data_byte),
		.fill_nx  (tx_fill_nx),
		.empty    (tx_empty),
		.full     (tx_full),
		.rdata_s1 (tx_rdata_s1)
	);

	always_comb begin
		res    = '0;
		rts_nx = rts_q;
		case (req_word.opcode)
			OP_LINE_RX: begin
				res.rx_dropped     = rx_full;
				res.reboot_request = (req_word.data_byte == REBOOT_CHAR) && reboot_en_q;
				if (LW'(rx_fill_nx) >= LW'(stop_q))
					rts_nx = 1'b0;
			end
			OP_HOST_READ: begin
				res.read_valid = !rx_empty;
				if (!rx_empty && (LW'(rx_fill_nx) < LW'(start_q)))
					rts_nx = 1'b1;
			end
			OP_HOST_WRITE: begin
				res.tx_rejected = tx_full;
			end
			OP_TX_READY: begin
				res.tx_valid          = !tx_empty && req_word.cts_asserted;
				res.tx_stalled_by_cts = !tx_empty && !req_word.cts_asserted;
			end
			default: ;
		endcase
		res.rts_asserted = rts_nx;
		res.rx_fill      = 8'(rx_fill_nx);
		res.tx_fill      = 8'(tx_fill_nx);
		res.rx_ready     = (rx_fill_nx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rts_q    <= 1'b1;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				rts_q    <= rts_nx;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_s1 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q      <= RTS_STOP_RST;
			start_q     <= RTS_START_RST;
			reboot_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RTS_STOP:  stop_q      <= cfg_wdata;
				CFG_RTS_START: start_q     <= cfg_wdata;
				CFG_REBOOT_EN: reboot_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	uartrb_oreg u_oreg (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.res_s1      (res_s1),
		.tx_rdata_s1 (tx_rdata_s1),
		.rx_rdata_s1 (rx_rdata_s1),
		.stall       (rsp_stall),
		.take        (take),
		.valid       (rsp_valid),
		.word        (rsp_word)
	);

	// rx_fill and tx_fill are only informative while RING_DEPTH <= 256

endmodule

// ===== hw/rtl/uartrb_chk.sv =====
module uartrb_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input uartrb_pkg::rsp_t rsp_word
);
	import uartrb_pkg::*;

	// a held response word does not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("response word changed while stalled");

	// a new response needs a request taken before the read and output registers
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("response without a request");

	// bytes are zero unless the matching valid is set
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.tx_valid || rsp_word.tx_byte == 8'd0)
			&& (rsp_word.read_valid || rsp_word.read_byte == 8'd0))
		else $error("byte set without its valid flag");

	// one word reports the outcome of a single event
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $countones({rsp_word.tx_valid || rsp_word.tx_stalled_by_cts,
			rsp_word.read_valid, rsp_word.tx_rejected,
			rsp_word.rx_dropped || rsp_word.reboot_request}) <= 1)
		else $error("flags from more than one event");

endmodule

bind uart_ring_buffers_rts_cts uartrb_chk u_uartrb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);

// ===== dv/uart_ring_buffers_rts_cts_tb.sv =====
`timescale 1ns / 100ps

module uart_ring_buffers_rts_cts_tb;
	import uartrb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_AFTER = 200;
	localparam int unsigned HOLD_CYCLES = 400;

	class uart_ring_checker;
		logic [7:0] rx_mem [256];
		logic [7:0] tx_mem [256];
		logic [7:0] rx_last_in, rx_next_out, tx_last_in, tx_next_out;
		logic [7:0] stop_level, start_level;
		bit rts_on, reboot_on;
		rsp_t due_replies [$];
		int unsigned errors, checked_count;

		function new();
			rx_last_in = 8'd0;
			rx_next_out = 8'd1;
			tx_last_in = 8'd0;
			tx_next_out = 8'd1;
			rts_on = 1'b1;
			stop_level = RTS_STOP_RST;
			start_level = RTS_START_RST;
			reboot_on = 1'b1;
			errors = 0;
			checked_count = 0;
		endfunction

		function logic [7:0] ring_fill(logic [7:0] last_in, logic [7:0] next_out);
			return last_in + 8'd1 - next_out;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_RTS_STOP:  stop_level = val;
				CFG_RTS_START: start_level = val;
				CFG_REBOOT_EN: reboot_on = val[0];
				default: ;
			endcase
		endfunction

		// works out the reply word for one accepted event
		function void take_event(req_t w);
			rsp_t e;
			e = '0;
			case (w.opcode)
				OP_LINE_RX: begin
					if (w.data_byte == REBOOT_CHAR && reboot_on)
						e.reboot_request = 1'b1;
					if (8'(rx_last_in + 8'd2) == rx_next_out) begin
						e.rx_dropped = 1'b1;
					end else begin
						rx_last_in = rx_last_in + 8'd1;
						rx_mem[rx_last_in] = w.data_byte;
					end
					if (ring_fill(rx_last_in, rx_next_out) >= stop_level)
						rts_on = 1'b0;
				end
				OP_HOST_READ: begin
					if (8'(rx_last_in + 8'd1) != rx_next_out) begin
						e.read_valid = 1'b1;
						e.read_byte = rx_mem[rx_next_out];
						rx_next_out = rx_next_out + 8'd1;
						if (ring_fill(rx_last_in, rx_next_out) < start_level)
							rts_on = 1'b1;
					end
				end
				OP_HOST_WRITE: begin
					if (8'(tx_last_in + 8'd2) == tx_next_out) begin
						e.tx_rejected = 1'b1;
					end else begin
						tx_last_in = tx_last_in + 8'd1;
						tx_mem[tx_last_in] = w.data_byte;
					end
				end
				default: begin
					if (8'(tx_last_in + 8'd1) != tx_next_out) begin
						if (w.cts_asserted) begin
							e.tx_valid = 1'b1;
							e.tx_byte = tx_mem[tx_next_out];
							tx_next_out = tx_next_out + 8'd1;
						end else begin
							e.tx_stalled_by_cts = 1'b1;
						end
					end
				end
			endcase
			e.rts_asserted = rts_on;
			e.rx_fill = ring_fill(rx_last_in, rx_next_out);
			e.tx_fill = ring_fill(tx_last_in, tx_next_out);
			e.rx_ready = (e.rx_fill != 8'd0);
			due_replies.push_back(e);
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			end
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			checked_count++;
			if (due_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				return;
			end
			want = due_replies.pop_front();
			cmp_field("tx_valid", want.tx_valid, got.tx_valid);
			cmp_field("tx_byte", want.tx_byte, got.tx_byte);
			cmp_field("read_valid", want.read_valid, got.read_valid);
			cmp_field("read_byte", want.read_byte, got.read_byte);
			cmp_field("rts_asserted", want.rts_asserted, got.rts_asserted);
			cmp_field("rx_fill", want.rx_fill, got.rx_fill);
			cmp_field("tx_fill", want.tx_fill, got.tx_fill);
			cmp_field("rx_dropped", want.rx_dropped, got.rx_dropped);
			cmp_field("tx_rejected", want.tx_rejected, got.tx_rejected);
			cmp_field("tx_stalled_by_cts", want.tx_stalled_by_cts, got.tx_stalled_by_cts);
			cmp_field("reboot_request", want.reboot_request, got.reboot_request);
			cmp_field("rx_ready", want.rx_ready, got.rx_ready);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_word;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_word;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	uart_ring_checker sb;
	int unsigned cycle_count;
	int unsigned burst_left;
	bit long_hold_done;

	uart_ring_buffers_rts_cts DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word(req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word(rsp_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_reply(rsp_word);
	end

	// receiver: segments of no, light or heavy stall, plus one long hold-off
	initial begin
		int unsigned seg_len;
		int unsigned mode;
		rsp_stall <= 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			seg_len = $urandom_range(1, 40);
			mode = $urandom_range(0, 2);
			repeat (seg_len) begin
				@(posedge clk);
				if (!long_hold_done && sb.checked_count >= HOLD_AFTER) begin
					long_hold_done = 1'b1;
					rsp_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 99) < 30);
					default: rsp_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
		end
	end

	task automatic send_word(input req_t w);
		req_valid <= 1'b1;
		req_word <= w;
		do @(posedge clk); while (req_stall);
		sb.take_event(w);
	endtask

	task automatic send_op(input op_t op, input logic [7:0] d, input logic c);
		req_t w;
		w.opcode = op;
		w.data_byte = d;
		w.cts_asserted = c;
		send_word(w);
	endtask

	task automatic idle_for(input int unsigned n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// no word in flight before a register write
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.due_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned n, input int unsigned w0, input int unsigned w1,
			input int unsigned w2, input int unsigned cts_pct);
		int unsigned r;
		op_t op;
		logic [7:0] d;
		for (int unsigned i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				if ($urandom_range(0, 3) != 0)
					idle_for($urandom_range(1, 8));
			end
			r = $urandom_range(0, 99);
			if (r < w0)
				op = OP_LINE_RX;
			else if (r < w0 + w1)
				op = OP_HOST_READ;
			else if (r < w0 + w1 + w2)
				op = OP_HOST_WRITE;
			else
				op = OP_TX_READY;
			d = ($urandom_range(0, 19) == 0) ? REBOOT_CHAR : 8'($urandom);
			send_op(op, d, $urandom_range(0, 99) < cts_pct);
			burst_left--;
		end
	endtask

	initial begin
		sb = new();
		burst_left = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset settings
		send_op(OP_LINE_RX, 8'h00, 1'b0);
		send_op(OP_LINE_RX, 8'hff, 1'b1);
		send_op(OP_LINE_RX, REBOOT_CHAR, 1'b0);
		send_op(OP_LINE_RX, 8'h80, 1'b1);
		send_op(OP_HOST_READ, 8'hff, 1'b1);
		send_op(OP_HOST_READ, 8'h00, 1'b0);
		send_op(OP_HOST_READ, 8'h55, 1'b1);
		send_op(OP_HOST_READ, 8'haa, 1'b0);
		send_op(OP_HOST_READ, 8'hff, 1'b1);
		send_op(OP_HOST_WRITE, 8'h00, 1'b0);
		send_op(OP_HOST_WRITE, 8'hff, 1'b1);
		send_op(OP_HOST_WRITE, 8'h5a, 1'b0);
		send_op(OP_TX_READY, 8'hff, 1'b0);
		send_op(OP_TX_READY, 8'h00, 1'b1);
		send_op(OP_TX_READY, 8'hff, 1'b1);
		send_op(OP_TX_READY, 8'h00, 1'b1);
		send_op(OP_TX_READY, 8'hff, 1'b1);
		send_op(OP_TX_READY, 8'h00, 1'b0);
		send_op(OP_HOST_WRITE, 8'h01, 1'b1);
		send_op(OP_HOST_READ, 8'h00, 1'b0);

		// receive ring driven to full, long hold-off lands here
		settle();
		write_reg(CFG_RTS_STOP, 8'd255);
		write_reg(CFG_RTS_START, 8'd0);
		write_reg(CFG_REBOOT_EN, 8'd1);
		write_reg(CFG_UNUSED, 8'hff);
		end_writes();
		run_phase(400, 80, 8, 6, 50);

		// transmit ring driven to full with cts mostly low
		settle();
		write_reg(CFG_RTS_STOP, 8'd0);
		write_reg(CFG_RTS_START, 8'd255);
		write_reg(CFG_REBOOT_EN, 8'd0);
		end_writes();
		run_phase(450, 5, 30, 62, 40);

		// draining both rings
		settle();
		write_reg(CFG_RTS_STOP, 8'd64);
		write_reg(CFG_RTS_START, 8'd32);
		write_reg(CFG_UNUSED, 8'h00);
		end_writes();
		run_phase(250, 15, 35, 15, 80);

		settle();
		write_reg(CFG_RTS_STOP, 8'($urandom));
		write_reg(CFG_RTS_START, 8'($urandom));
		write_reg(CFG_REBOOT_EN, 8'd1);
		end_writes();
		run_phase(200, 30, 25, 25, 60);

		req_valid <= 1'b0;
		while (sb.due_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
